@@ design/upd_pkg.sv @@
// upd_pkg: shared types, character constants and hex helpers for the
// percent decoder; no dependencies, compiled first
`default_nettype none

package upd_pkg;

    // characters that the decoder recognizes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [3:0] HEX_ALPHA_OFFSET = 4'd9;

    // most bytes a single request can produce
    localparam int unsigned MAX_BYTES = 3;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // work handed from the front to the back: up to three bytes in order
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                count;
        logic                      last;
    } upd_cmd_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } upd_qstat_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = ((c >= CH_0) && (c <= CH_9)) ||
                 ((c >= CH_UA) && (c <= CH_UF)) ||
                 ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    // nibble value of a character known to be a hex digit
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= CH_9)
        begin
            hex_nibble = c[3:0];
        end
        else
        begin
            hex_nibble = c[3:0] + HEX_ALPHA_OFFSET;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/upd_if.sv @@
// upd_if: valid/ready channel interfaces for encoded input and decoded output
// no dependencies
`default_nettype none

interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_byte;
    logic       final_byte;

    modport source (output valid, output decoded_byte, output final_byte, input ready);
    modport sink   (input valid, input decoded_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ design/url_percent_decoder_top.sv @@
// url_percent_decoder_top: streaming percent decoder top level
// depends on upd_pkg, upd_if, upd_front, upd_queue, upd_back
//
// Takes one encoded byte per request on enc and yields decoded bytes on dec,
// with final_byte set on the last decoded byte of each string. "%hh" (either
// case) becomes one byte, '+' becomes a space, anything else passes as is;
// a broken escape is replayed literally. Input is accepted every cycle while
// the two-entry command queue has room, and the output register drains one
// byte per cycle while dec is ready, so a plain stream runs at one byte per
// clock, each command passing through the queue and then the output register.
// A broken escape expands to two or three output bytes; the output
// register's one-byte-per-cycle drain sets the sustained rate.
`default_nettype none

module url_percent_decoder_top
    import upd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    upd_in_if.sink    enc,
    upd_out_if.source dec
);

    upd_qstat_t qstat;
    upd_cmd_t   push_cmd;
    upd_cmd_t   head;
    logic       push;
    logic       pop;

    upd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc),
        .qstat (qstat),
        .push  (push),
        .cmd   (push_cmd)
    );

    upd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    upd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .dec   (dec)
    );

endmodule

`default_nettype wire

@@ design/upd_front.sv @@
// upd_front: accepts encoded bytes, tracks a pending escape and turns each
// request into a command of up to three output bytes; uses upd_pkg
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    upd_in_if.sink          enc,
    input  wire upd_qstat_t qstat,
    output logic            push,
    output upd_cmd_t        cmd
);

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_PCT   = 2'd1,
        HELD_DIGIT = 2'd2
    } held_t;

    held_t      held_reg, held_next;
    logic [7:0] digit_reg, digit_next;

    logic       accept;
    logic [7:0] c;
    logic       eos;
    logic       c_hex;
    logic       fresh_hold;
    logic [7:0] fresh_byte;

    assign enc.ready = !qstat.full;
    assign accept    = enc.valid && enc.ready;
    assign c         = enc.data_byte;
    assign eos       = enc.end_of_string;
    assign c_hex     = is_hex(c);

    // a fresh byte either opens an escape or passes with plus mapped to space
    assign fresh_hold = (c == CH_PERCENT) && !eos;
    assign fresh_byte = (c == CH_PLUS) ? CH_SPACE : c;

    // classify the byte against the held escape
    always_comb
    begin
        held_next  = HELD_NONE;
        digit_next = digit_reg;
        cmd        = '0;
        cmd.last   = eos;
        case (held_reg)
            HELD_PCT:
            begin
                if (c_hex && !eos)
                begin
                    held_next  = HELD_DIGIT;
                    digit_next = c;
                end
                else
                begin
                    cmd.bytes[0] = CH_PERCENT;
                    if (fresh_hold)
                    begin
                        held_next = HELD_PCT;
                        cmd.count = 2'd1;
                    end
                    else
                    begin
                        cmd.bytes[1] = fresh_byte;
                        cmd.count    = 2'd2;
                    end
                end
            end
            HELD_DIGIT:
            begin
                if (c_hex)
                begin
                    cmd.bytes[0] = {hex_nibble(digit_reg), hex_nibble(c)};
                    cmd.count    = 2'd1;
                end
                else
                begin
                    cmd.bytes[0] = CH_PERCENT;
                    cmd.bytes[1] = digit_reg;
                    if (fresh_hold)
                    begin
                        held_next = HELD_PCT;
                        cmd.count = 2'd2;
                    end
                    else
                    begin
                        cmd.bytes[2] = fresh_byte;
                        cmd.count    = 2'd3;
                    end
                end
            end
            default:
            begin
                if (fresh_hold)
                begin
                    held_next = HELD_PCT;
                end
                else
                begin
                    cmd.bytes[0] = fresh_byte;
                    cmd.count    = 2'd1;
                end
            end
        endcase
    end

    assign push = accept && (cmd.count != 2'd0);

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= HELD_NONE;
            digit_reg <= '0;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

@@ design/upd_queue.sv @@
// upd_queue: two-entry command queue between front and back
// uses upd_pkg
`default_nettype none

module upd_queue
    import upd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire upd_cmd_t push_cmd,
    input  wire logic     pop,
    output upd_cmd_t      head,
    output upd_qstat_t    qstat
);

    upd_cmd_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;

    assign qstat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.not_empty = (count_reg != '0);
    assign head            = mem[rd_ptr_reg];
    assign do_pop          = pop && qstat.not_empty;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/upd_back.sv @@
// upd_back: walks the bytes of the head command into the output register,
// one byte per cycle while the output is not stalled; uses upd_pkg
`default_nettype none

module upd_back
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire upd_cmd_t   head,
    input  wire upd_qstat_t qstat,
    output logic            pop,
    upd_out_if.source       dec
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       final_reg, final_next;

    logic       load;
    logic       take;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = !valid_reg || dec.ready;
    assign take   = load && qstat.not_empty;
    assign at_end = (idx_reg == (head.count - 2'd1));
    assign pop    = take && at_end;

    // pick the current byte of the head command
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            2'd2:    sel_byte = head.bytes[2];
            default: sel_byte = head.bytes[0];
        endcase
    end

    // output register and byte index
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        final_next = final_reg;
        if (load)
        begin
            valid_next = qstat.not_empty;
        end
        if (take)
        begin
            byte_next  = sel_byte;
            final_next = head.last && at_end;
            idx_next   = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        final_reg <= final_next;
    end

    assign dec.valid        = valid_reg;
    assign dec.decoded_byte = byte_reg;
    assign dec.final_byte   = final_reg;

endmodule

`default_nettype wire

@@ design/upd_checker.sv @@
// upd_checker: port-level assertions for the percent decoder, bound to
// url_percent_decoder_top; no other dependencies
`default_nettype none

module upd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       enc_valid,
    input wire logic       enc_ready,
    input wire logic       dec_valid,
    input wire logic       dec_ready,
    input wire logic [7:0] dec_decoded_byte,
    input wire logic       dec_final_byte
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid && $stable(dec_decoded_byte)
            && $stable(dec_final_byte))
        else $error("stalled output changed");

    // a new result is always preceded by some accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dec_valid) |-> $past(enc_valid && enc_ready, 2))
        else $error("output appeared without a prior request");

    // the input only backs up behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !enc_ready |-> dec_valid)
        else $error("input stalled while output idle");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .enc_valid        (enc.valid),
    .enc_ready        (enc.ready),
    .dec_valid        (dec.valid),
    .dec_ready        (dec.ready),
    .dec_decoded_byte (dec.decoded_byte),
    .dec_final_byte   (dec.final_byte)
);

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking testbench for url_percent_decoder_top, driving encoded
// bytes with random gaps and checking decoded bytes against an in-bench decoder
// depends on upd_pkg, upd_if and the decoder RTL
`timescale 1ns / 100ps

module tb;
    import upd_pkg::*;

    // one encoded byte waiting to be sent, with the gap that goes before it
    typedef struct {
        logic [7:0]  ch;
        logic        eos;
        int unsigned gap;
        bit          drain_first;
    } enc_req_t;

    // one decoded byte as the decoder should emit it
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } dec_byte_t;

    logic clk;
    logic rst_n;

    upd_in_if  enc_bus ();
    upd_out_if dec_bus ();

    url_percent_decoder_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc_bus),
        .dec   (dec_bus)
    );

    enc_req_t    enc_backlog[$];
    dec_byte_t   dec_expect[$];

    // decoder state mirrored by the bench
    logic [1:0]  held_cnt;
    logic [7:0]  held_digit;

    bit          enc_fire;
    bit          dec_fire;
    bit          gap_armed;
    bit          next_valid;
    bit          sink_eager;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned reqs_total;
    int unsigned reqs_taken;
    int unsigned fault_count;
    enc_req_t    req_now;
    dec_byte_t   want;

    string hex_chars = "0123456789abcdefABCDEF";
    string edge_chars = "/:@G`g";

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // value of a hex digit, or -1 for anything else
    function automatic int hex_val(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
        begin
            return int'(c) - int'(CH_0);
        end
        if (c >= CH_UA && c <= CH_UF)
        begin
            return int'(c) - int'(CH_UA) + 10;
        end
        if (c >= CH_LA && c <= CH_LF)
        begin
            return int'(c) - int'(CH_LA) + 10;
        end
        return -1;
    endfunction

    task automatic push_decoded(input logic [7:0] b, inout int made);
        dec_expect.push_back('{ch: b, last: 1'b0});
        made++;
    endtask

    // byte seen outside an escape: may open one, '+' turns into a space
    task automatic scan_plain(input logic [7:0] c, input logic eos, inout int made);
        if (c == CH_PERCENT && !eos)
        begin
            held_cnt = 2'd1;
        end
        else
        begin
            push_decoded((c == CH_PLUS) ? CH_SPACE : c, made);
        end
    endtask

    // decode one accepted request and queue the bytes it should produce
    task automatic decode_step(input logic [7:0] c, input logic eos);
        int        v;
        int        hi;
        int        made;
        dec_byte_t tail;
        v = hex_val(c);
        made = 0;
        case (held_cnt)
            2'd1:
            begin
                held_cnt = 2'd0;
                if (v >= 0 && !eos)
                begin
                    held_cnt = 2'd2;
                    held_digit = c;
                end
                else
                begin
                    push_decoded(CH_PERCENT, made);
                    scan_plain(c, eos, made);
                end
            end
            2'd2:
            begin
                hi = hex_val(held_digit);
                held_cnt = 2'd0;
                if (v >= 0 && hi >= 0)
                begin
                    push_decoded({hi[3:0], v[3:0]}, made);
                end
                else
                begin
                    push_decoded(CH_PERCENT, made);
                    push_decoded(held_digit, made);
                    scan_plain(c, eos, made);
                end
            end
            default:
            begin
                held_cnt = 2'd0;
                scan_plain(c, eos, made);
            end
        endcase
        // end of string: nothing stays held, last byte gets the mark
        if (eos)
        begin
            held_cnt = 2'd0;
            if (made > 0)
            begin
                tail = dec_expect.pop_back();
                tail.last = 1'b1;
                dec_expect.push_back(tail);
            end
        end
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic int unsigned draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic add_req(input logic [7:0] ch, input logic eos, input int unsigned gap,
                           input bit drain);
        enc_backlog.push_back('{ch: ch, eos: eos, gap: gap, drain_first: drain});
    endtask

    // a whole string, final flag on its last byte
    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            add_req(s[i], i == s.len() - 1, draw_gap(1'b0), 1'b0);
        end
    endtask

    function automatic logic [7:0] rand_hex();
        return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
    endfunction

    // a byte just outside the hex ranges, or any byte that is not a digit
    function automatic logic [7:0] rand_nonhex();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0)
        begin
            return edge_chars[$urandom_range(0, edge_chars.len() - 1)];
        end
        c = 8'($urandom_range(0, 255));
        while (hex_val(c) >= 0)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // monitor: sample both channels, check results, then predict new requests
    always @(posedge clk)
    begin
        enc_fire = rst_n && enc_bus.valid && enc_bus.ready;
        dec_fire = rst_n && dec_bus.valid && dec_bus.ready;
        if (dec_fire)
        begin
            if (dec_expect.size() == 0)
            begin
                note_fault($sformatf("unexpected byte %02h final %0b",
                                     dec_bus.decoded_byte, dec_bus.final_byte));
            end
            else
            begin
                want = dec_expect.pop_front();
                if (dec_bus.decoded_byte !== want.ch || dec_bus.final_byte !== want.last)
                begin
                    note_fault($sformatf("byte exp %02h got %02h, final exp %0b got %0b",
                                         want.ch, dec_bus.decoded_byte,
                                         want.last, dec_bus.final_byte));
                end
            end
        end
        if (enc_fire)
        begin
            decode_step(enc_bus.data_byte, enc_bus.end_of_string);
            reqs_taken++;
        end
    end

    // request driver: gap before each request, optional wait for a drained output
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            enc_bus.valid <= 1'b0;
        end
        else if (!enc_bus.valid || enc_fire)
        begin
            next_valid = 1'b0;
            if (enc_backlog.size() > 0)
            begin
                if (!gap_armed)
                begin
                    gap_left = enc_backlog[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (!(enc_backlog[0].drain_first && dec_expect.size() != 0))
                begin
                    req_now = enc_backlog.pop_front();
                    enc_bus.data_byte <= req_now.ch;
                    enc_bus.end_of_string <= req_now.eos;
                    next_valid = 1'b1;
                    gap_armed = 1'b0;
                end
            end
            enc_bus.valid <= next_valid;
        end
    end

    // result sink: random stall after each accepted byte, with eager stretches
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            dec_bus.ready <= 1'b0;
        end
        else
        begin
            if (dec_fire)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    sink_eager = !sink_eager;
                end
                stall_left = sink_eager ? 0 : $urandom_range(0, 16);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                dec_bus.ready <= 1'b0;
            end
            else
            begin
                dec_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [7:0]  text[$];
        int unsigned random_reqs;
        int unsigned ntok;
        int          i;
        bit          burst;
        bit          mid_pause_done;
        bit          pause_here;

        enc_bus.valid = 1'b0;
        enc_bus.data_byte = 8'h00;
        enc_bus.end_of_string = 1'b0;
        dec_bus.ready = 1'b0;
        rst_n = 1'b0;
        held_cnt = 2'd0;
        held_digit = 8'h00;
        enc_fire = 1'b0;
        dec_fire = 1'b0;
        gap_armed = 1'b0;
        sink_eager = 1'b0;
        gap_left = 0;
        stall_left = 0;
        reqs_taken = 0;
        fault_count = 0;
        random_reqs = 0;
        mid_pause_done = 1'b0;

        // directed: byte extremes, digit cases, plus, broken escapes, early ends
        add_req(8'h00, 1'b0, draw_gap(1'b0), 1'b0);
        add_req(8'hFF, 1'b1, draw_gap(1'b0), 1'b0);
        add_text("%4a");
        add_text("%Ff+");
        add_text("%g%");
        add_text("%+");
        add_text("%1zx");
        add_text("%%41");
        add_text("%9");

        // random strings, mostly well-formed escapes mixed with noise
        while (random_reqs < 256)
        begin
            burst = ($urandom_range(0, 2) == 0);
            text.delete();
            ntok = $urandom_range(1, 8);
            repeat (ntok)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        text.push_back(CH_PERCENT);
                        text.push_back(rand_hex());
                        text.push_back(rand_hex());
                    end
                    4: text.push_back(CH_PLUS);
                    5: text.push_back(CH_PERCENT);
                    6:
                    begin
                        text.push_back(CH_PERCENT);
                        text.push_back(rand_hex());
                        text.push_back(rand_nonhex());
                    end
                    7: text.push_back(($urandom_range(0, 1) == 0) ? rand_hex() : rand_nonhex());
                    default: text.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            // hold off until the output has drained, at the start and midway
            pause_here = (random_reqs == 0) || (random_reqs >= 128 && !mid_pause_done);
            if (random_reqs >= 128)
            begin
                mid_pause_done = 1'b1;
            end
            for (i = 0; i < text.size(); i++)
            begin
                add_req(text[i], i == text.size() - 1, draw_gap(burst), pause_here && i == 0);
            end
            random_reqs += text.size();
        end
        reqs_total = enc_backlog.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: all requests taken, all bytes seen, then a short settle
        while (reqs_taken < reqs_total)
        begin
            @(negedge clk);
        end
        while (dec_expect.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        if (dec_expect.size() != 0)
        begin
            note_fault($sformatf("%0d decoded bytes never arrived", dec_expect.size()));
        end
        if (fault_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/upd_pkg.sv
design/upd_if.sv
design/upd_front.sv
design/upd_queue.sv
design/upd_back.sv
design/url_percent_decoder_top.sv
design/upd_checker.sv
tb/tb.sv
